// ----- rtl/core/ctw_pkg.sv -----
package ctw_pkg;

	// field widths fixed by the port list
	localparam int CELL_W    = 16;
	localparam int CHAR_W    = 8;
	localparam int COLOR_W   = 4;
	localparam int CUR_COL_W = 7;
	localparam int CUR_ROW_W = 5;
	localparam int CUR_LIN_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CMD_W     = 2;

	// holds row*COLUMNS+col for any 5-bit row and COLUMNS up to 128
	localparam int LIN_W = 14;

	localparam int TAB_STEP = 4;

	localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;

	localparam logic [CFG_IDX_W-1:0] REG_FG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BG = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUTC  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_PUTAT = 2'd2,
		CMD_READ  = 2'd3
	} ctw_cmd_t;

	typedef struct packed {
		logic              start;
		logic              scroll;
		logic [CELL_W-1:0] blank;
	} ctw_sweep_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ctw_sweep_sts_t;

endpackage

// ----- rtl/core/ctw_ram.sv -----
module ctw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/ctw_sweep.sv -----
module ctw_sweep #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ctw_pkg::ctw_sweep_req_t             req,
	output ctw_pkg::ctw_sweep_sts_t             sts,
	output logic                                re,
	output logic [$clog2(ROWS*COLUMNS)-1:0]     raddr,
	input  logic [ctw_pkg::CELL_W-1:0]          rdata,
	output logic                                we,
	output logic [$clog2(ROWS*COLUMNS)-1:0]     waddr,
	output logic [ctw_pkg::CELL_W-1:0]          wdata
);

	import ctw_pkg::*;

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int AW     = $clog2(CELLS);
	localparam int LAST_I = CELLS - 1;
	localparam int FILL_I = CELLS - COLUMNS;

	localparam logic [AW-1:0] COL_A  = COLUMNS[AW-1:0];
	localparam logic [AW-1:0] LAST_A = LAST_I[AW-1:0];
	localparam logic [AW-1:0] FILL_A = FILL_I[AW-1:0];

	typedef enum logic [1:0] {
		SW_IDLE,
		SW_COPY,
		SW_DRAIN,
		SW_FILL
	} sw_state_t;

	sw_state_t       state_q;
	logic [AW-1:0]   addr_q;
	logic            cp_v_s1;
	logic [AW-1:0]   cp_addr_s1;

	// copy: read row r+1, write it to row r in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SW_IDLE;
			addr_q     <= '0;
			cp_v_s1    <= 1'b0;
			cp_addr_s1 <= '0;
		end else begin
			cp_v_s1    <= (state_q == SW_COPY);
			cp_addr_s1 <= addr_q - COL_A;
			unique case (state_q)
				SW_IDLE: begin
					if (req.start) begin
						state_q <= req.scroll ? SW_COPY : SW_FILL;
						addr_q  <= req.scroll ? COL_A : '0;
					end
				end
				SW_COPY: begin
					if (addr_q == LAST_A) begin
						state_q <= SW_DRAIN;
						addr_q  <= FILL_A;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				SW_DRAIN: begin
					state_q <= SW_FILL;
				end
				SW_FILL: begin
					if (addr_q == LAST_A) begin
						state_q <= SW_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				default: state_q <= SW_IDLE;
			endcase
		end
	end

	assign re    = (state_q == SW_COPY);
	assign raddr = addr_q;
	assign we    = cp_v_s1 || (state_q == SW_FILL);
	assign waddr = cp_v_s1 ? cp_addr_s1 : addr_q;
	assign wdata = cp_v_s1 ? rdata : req.blank;

	assign sts.busy = (state_q != SW_IDLE);
	assign sts.done = (state_q == SW_FILL) && (addr_q == LAST_A);

endmodule

// ----- rtl/core/text_console_writer.sv -----
// Text-mode console engine over a ROWS x COLUMNS grid of 16-bit cells (character in the
// low byte, foreground nibble in bits 11:8, background nibble in bits 15:12). Commands:
// put char at cursor (LF moves down a row, CR homes the column, TAB steps 4 columns and
// wraps at the right edge, anything else is written and the cursor advances with wrap),
// clear screen, put char at a given cell, and read a cell. Every command returns one
// result item with the cursor after the command. The grid lives in one simple dual-port
// RAM with one write port, and that write port sets the rate: a clear or a put-char that
// scrolls rewrites every cell once through it in a sweep, a read waits for the RAM data,
// and input is stalled until the command is done. A finished result waits in a one-entry
// holding stage in front of the output register, so the next item is taken while the last
// one is still waiting downstream. The cell RAM is not cleared after reset: issue a clear
// before reading cells. Colors (cfg index 0 foreground, 1 background) must be written only
// while idle; the block itself does not enforce it.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// command channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ctw_pkg::CMD_W-1:0]         cmd,
	input  logic [ctw_pkg::CHAR_W-1:0]        char_code,
	input  logic [ctw_pkg::CUR_COL_W-1:0]     col,
	input  logic [ctw_pkg::CUR_ROW_W-1:0]     row,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ctw_pkg::CUR_COL_W-1:0]     cursor_col,
	output logic [ctw_pkg::CUR_ROW_W-1:0]     cursor_row,
	output logic [ctw_pkg::CUR_LIN_W-1:0]     cursor_linear,
	output logic [ctw_pkg::CELL_W-1:0]        cell_data,
	output logic                              scrolled,
	// color registers
	input  logic                              cfg_we,
	input  logic [ctw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ctw_pkg::COLOR_W-1:0]       cfg_data
);

	import ctw_pkg::*;

	localparam int CELLS    = ROWS * COLUMNS;
	localparam int AW       = $clog2(CELLS);
	localparam int CW       = $clog2(COLUMNS);
	localparam int RW       = $clog2(ROWS);
	localparam int COL_LAST_I = COLUMNS - 1;
	localparam int ROW_LAST_I = ROWS - 1;

	localparam logic [CW:0]   COL_LIM  = COLUMNS[CW:0];
	localparam logic [CW:0]   TAB_INC  = TAB_STEP[CW:0];
	localparam logic [CW-1:0] COL_LAST = COL_LAST_I[CW-1:0];
	localparam logic [RW-1:0] ROW_LAST = ROW_LAST_I[RW-1:0];

	typedef enum logic [1:0] {
		ST_IDLE,   // waiting for a command
		ST_EXEC,   // cursor update, cell write or read issue, sweep start
		ST_RDATA,  // read data back from the cell RAM
		ST_SWEEP   // scroll or clear running in the sweep unit
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cur_col_q;
	logic [RW-1:0]           cur_row_q;
	logic [COLOR_W-1:0]      fg_q;
	logic [COLOR_W-1:0]      bg_q;
	logic                    pend_v_q;
	logic                    out_v_q;

	// accepted command
	ctw_cmd_t                cmd_s1;
	logic [CHAR_W-1:0]       char_s1;
	logic [CUR_COL_W-1:0]    col_s1;
	logic [CUR_ROW_W-1:0]    row_s1;

	// holding stage between the engine and the output register
	logic [CW-1:0]           pend_col_q;
	logic [RW-1:0]           pend_row_q;
	logic [CELL_W-1:0]       pend_data_q;
	logic                    pend_scr_q;

	logic [CUR_COL_W-1:0]    out_col_q;
	logic [CUR_ROW_W-1:0]    out_row_q;
	logic [CUR_LIN_W-1:0]    out_lin_q;
	logic [CELL_W-1:0]       out_data_q;
	logic                    out_scr_q;

	logic                    in_acc;
	logic                    out_load;
	logic                    pend_load;
	logic [CW:0]             tab_sum;
	logic [CW-1:0]           nxt_col;
	logic [RW-1:0]           nxt_row;
	logic                    row_adv;
	logic                    do_scroll;
	logic                    prn;
	logic                    at_ok;
	logic [LIN_W-1:0]        lin_row;
	logic [LIN_W-1:0]        lin_col;
	logic [LIN_W-1:0]        eng_lin;
	logic [LIN_W-1:0]        res_lin;
	logic                    eng_we;
	logic                    eng_re;
	logic [CW-1:0]           res_col;
	logic [RW-1:0]           res_row;
	logic [CELL_W-1:0]       res_data;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [CELL_W-1:0]       ram_wdata;
	logic                    ram_re;
	logic [AW-1:0]           ram_raddr;
	logic [CELL_W-1:0]       ram_rdata;

	ctw_sweep_req_t          sw_req;
	ctw_sweep_sts_t          sw_sts;
	logic                    sw_re;
	logic [AW-1:0]           sw_raddr;
	logic                    sw_we;
	logic [AW-1:0]           sw_waddr;
	logic [CELL_W-1:0]       sw_wdata;

	// Output register takes the held result when it is empty or being drained.
	assign out_load = pend_v_q && (!out_v_q || !out_stall);
	// Take a command when idle and the holding stage is (or is about to be) free.
	assign in_stall = !((state_q == ST_IDLE) && !sw_sts.busy && (!pend_v_q || out_load));
	assign in_acc   = in_valid && !in_stall;

	// put-char cursor movement
	always_comb begin
		tab_sum = {1'b0, cur_col_q} + TAB_INC;
		nxt_col = cur_col_q;
		row_adv = 1'b0;
		prn     = 1'b0;
		if (char_s1 == CHAR_LF) begin
			row_adv = 1'b1;
		end else if (char_s1 == CHAR_CR) begin
			nxt_col = '0;
		end else if (char_s1 == CHAR_TAB) begin
			// a tab past the right edge wraps like a printed character
			if (tab_sum >= COL_LIM) begin
				nxt_col = '0;
				row_adv = 1'b1;
			end else begin
				nxt_col = tab_sum[CW-1:0];
			end
		end else begin
			prn = 1'b1;
			if (cur_col_q == COL_LAST) begin
				nxt_col = '0;
				row_adv = 1'b1;
			end else begin
				nxt_col = cur_col_q + 1'b1;
			end
		end
		do_scroll = row_adv && (cur_row_q == ROW_LAST);
		nxt_row   = (row_adv && !do_scroll) ? cur_row_q + 1'b1 : cur_row_q;
	end

	// put-at / read target inside the grid
	assign at_ok = (int'(col_s1) < COLUMNS) && (int'(row_s1) < ROWS);

	// one shared row*COLUMNS+col for the cursor cell and the put-at / read cell
	assign lin_row = (cmd_s1 == CMD_PUTC) ? LIN_W'(cur_row_q) : LIN_W'(row_s1);
	assign lin_col = (cmd_s1 == CMD_PUTC) ? LIN_W'(cur_col_q) : LIN_W'(col_s1);
	assign eng_lin = lin_row * LIN_W'(COLUMNS) + lin_col;

	assign eng_we = (state_q == ST_EXEC) &&
		(((cmd_s1 == CMD_PUTC) && prn) || ((cmd_s1 == CMD_PUTAT) && at_ok));
	assign eng_re = (state_q == ST_EXEC) && (cmd_s1 == CMD_READ) && at_ok;

	assign sw_req.start  = (state_q == ST_EXEC) &&
		(((cmd_s1 == CMD_PUTC) && do_scroll) || (cmd_s1 == CMD_CLEAR));
	assign sw_req.scroll = (cmd_s1 == CMD_PUTC);
	assign sw_req.blank  = {bg_q, fg_q, {CHAR_W{1'b0}}};

	// the engine and the sweep unit never use the RAM in the same cycle
	assign ram_we    = eng_we || sw_we;
	assign ram_waddr = sw_we ? sw_waddr : eng_lin[AW-1:0];
	assign ram_wdata = sw_we ? sw_wdata : {bg_q, fg_q, char_s1};
	assign ram_re    = eng_re || sw_re;
	assign ram_raddr = sw_re ? sw_raddr : eng_lin[AW-1:0];

	// result of the command in flight
	always_comb begin
		pend_load = 1'b0;
		unique case (state_q)
			ST_EXEC:  pend_load = ((cmd_s1 == CMD_PUTC) && !do_scroll) ||
			                      (cmd_s1 == CMD_PUTAT);
			ST_RDATA: pend_load = 1'b1;
			ST_SWEEP: pend_load = sw_sts.done;
			default:  pend_load = 1'b0;
		endcase
	end

	assign res_col  = ((state_q == ST_EXEC) && (cmd_s1 == CMD_PUTC)) ? nxt_col : cur_col_q;
	assign res_row  = ((state_q == ST_EXEC) && (cmd_s1 == CMD_PUTC)) ? nxt_row : cur_row_q;
	assign res_data = ((state_q == ST_RDATA) && at_ok) ? ram_rdata : '0;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_col_q <= '0;
			cur_row_q <= '0;
			fg_q      <= 4'd7;
			bg_q      <= '0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FG:  fg_q <= cfg_data;
					REG_BG:  bg_q <= cfg_data;
					default: ;
				endcase
			end

			if (pend_load) begin
				pend_v_q <= 1'b1;
			end else if (out_load) begin
				pend_v_q <= 1'b0;
			end

			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (cmd_s1)
						CMD_PUTC: begin
							cur_col_q <= nxt_col;
							cur_row_q <= nxt_row;
							state_q   <= do_scroll ? ST_SWEEP : ST_IDLE;
						end
						CMD_CLEAR: begin
							cur_col_q <= '0;
							cur_row_q <= '0;
							state_q   <= ST_SWEEP;
						end
						CMD_PUTAT: state_q <= ST_IDLE;
						CMD_READ:  state_q <= ST_RDATA;
						default:   state_q <= ST_IDLE;
					endcase
				end
				ST_RDATA: begin
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					if (sw_sts.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_lin = LIN_W'(pend_row_q) * LIN_W'(COLUMNS) + LIN_W'(pend_col_q);

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1  <= ctw_cmd_t'(cmd);
			char_s1 <= char_code;
			col_s1  <= col;
			row_s1  <= row;
		end
		if (pend_load) begin
			pend_col_q  <= res_col;
			pend_row_q  <= res_row;
			pend_data_q <= res_data;
			pend_scr_q  <= (state_q == ST_SWEEP) && (cmd_s1 == CMD_PUTC);
		end
		if (out_load) begin
			out_col_q  <= CUR_COL_W'(pend_col_q);
			out_row_q  <= CUR_ROW_W'(pend_row_q);
			out_lin_q  <= res_lin[CUR_LIN_W-1:0];
			out_data_q <= pend_data_q;
			out_scr_q  <= pend_scr_q;
		end
	end

	assign out_valid     = out_v_q;
	assign cursor_col    = out_col_q;
	assign cursor_row    = out_row_q;
	assign cursor_linear = out_lin_q;
	assign cell_data     = out_data_q;
	assign scrolled      = out_scr_q;

	ctw_sweep #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sw_req),
		.sts    (sw_sts),
		.re     (sw_re),
		.raddr  (sw_raddr),
		.rdata  (ram_rdata),
		.we     (sw_we),
		.waddr  (sw_waddr),
		.wdata  (sw_wdata)
	);

	ctw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ----- verif/tb_text_console_writer.sv -----
`timescale 1ns / 1ps

module tb_text_console_writer;
	import ctw_pkg::*;

	localparam int GRID_COLS   = 80;
	localparam int GRID_ROWS   = 25;
	localparam int GRID_CELLS  = GRID_COLS * GRID_ROWS;
	// a clear or a scroll walks every cell, so the quiet limit sits well above that
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [CMD_W-1:0]     cmd;
	logic [CHAR_W-1:0]    char_code;
	logic [CUR_COL_W-1:0] col;
	logic [CUR_ROW_W-1:0] row;
	logic                 out_valid;
	logic                 out_stall;
	logic [CUR_COL_W-1:0] cursor_col;
	logic [CUR_ROW_W-1:0] cursor_row;
	logic [CUR_LIN_W-1:0] cursor_linear;
	logic [CELL_W-1:0]    cell_data;
	logic                 scrolled;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COLOR_W-1:0]   cfg_data;

	// one result item as the console reports it
	typedef struct packed {
		logic [CUR_COL_W-1:0] ccol;
		logic [CUR_ROW_W-1:0] crow;
		logic [CUR_LIN_W-1:0] clin;
		logic [CELL_W-1:0]    data;
		logic                 scr;
	} console_report_t;

	// shadow copy of the console: grid, cursor and color registers
	logic [CELL_W-1:0]  shadow_cells [GRID_CELLS];
	int                 shadow_col = 0;
	int                 shadow_row = 0;
	logic [COLOR_W-1:0] fg_nib = 4'd7;
	logic [COLOR_W-1:0] bg_nib = 4'd0;

	console_report_t expected_reports [$];

	int fail_count   = 0;
	int quiet_cycles = 0;
	int hold_left    = 0;   // long receiver hold-off, counted down by the result sink
	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;

	text_console_writer #(
		.COLUMNS(GRID_COLS),
		.ROWS   (GRID_ROWS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.char_code    (char_code),
		.col          (col),
		.row          (row),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.cursor_linear(cursor_linear),
		.cell_data    (cell_data),
		.scrolled     (scrolled),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Applies one command to the shadow console and returns the report it must produce.
	function automatic console_report_t console_update(ctw_cmd_t op, logic [CHAR_W-1:0] ch,
			logic [CUR_COL_W-1:0] c, logic [CUR_ROW_W-1:0] r);
		console_report_t  res;
		logic [CELL_W-1:0] blank;
		int               lin;
		blank = {bg_nib, fg_nib, 8'h00};
		res   = '0;
		case (op)
		CMD_PUTC: begin
			if (ch == CHAR_LF) begin
				shadow_row++;
			end else if (ch == CHAR_CR) begin
				shadow_col = 0;
			end else if (ch == CHAR_TAB) begin
				// a tab past the right edge wraps like a printed character
				shadow_col += TAB_STEP;
				if (shadow_col >= GRID_COLS) begin
					shadow_col = 0;
					shadow_row++;
				end
			end else begin
				shadow_cells[shadow_row * GRID_COLS + shadow_col] = blank | CELL_W'(ch);
				shadow_col++;
				if (shadow_col >= GRID_COLS) begin
					shadow_col = 0;
					shadow_row++;
				end
			end
			// fell off the bottom: shift every row up, blank the last one
			if (shadow_row >= GRID_ROWS) begin
				for (int k = 0; k < GRID_CELLS - GRID_COLS; k++)
					shadow_cells[k] = shadow_cells[k + GRID_COLS];
				for (int k = GRID_CELLS - GRID_COLS; k < GRID_CELLS; k++)
					shadow_cells[k] = blank;
				shadow_row = GRID_ROWS - 1;
				res.scr    = 1'b1;
			end
		end
		CMD_CLEAR: begin
			for (int k = 0; k < GRID_CELLS; k++)
				shadow_cells[k] = blank;
			shadow_col = 0;
			shadow_row = 0;
		end
		CMD_PUTAT: begin
			if (c < GRID_COLS && r < GRID_ROWS)
				shadow_cells[r * GRID_COLS + c] = blank | CELL_W'(ch);
		end
		default: begin
			// off-grid reads return zero
			if (c < GRID_COLS && r < GRID_ROWS)
				res.data = shadow_cells[r * GRID_COLS + c];
		end
		endcase
		lin      = shadow_row * GRID_COLS + shadow_col;
		res.ccol = CUR_COL_W'(shadow_col);
		res.crow = CUR_ROW_W'(shadow_row);
		res.clin = CUR_LIN_W'(lin);
		return res;
	endfunction

	// mostly on the grid, one in ten off it (up to the field's all-ones value)
	function automatic logic [CUR_COL_W-1:0] rand_col();
		return CUR_COL_W'(($urandom_range(0, 9) == 0) ? $urandom_range(GRID_COLS, 127)
			: $urandom_range(0, GRID_COLS - 1));
	endfunction

	function automatic logic [CUR_ROW_W-1:0] rand_row();
		return CUR_ROW_W'(($urandom_range(0, 9) == 0) ? $urandom_range(GRID_ROWS, 31)
			: $urandom_range(0, GRID_ROWS - 1));
	endfunction

	// Offers one command item after a random gap and waits for the handshake.
	// Valid is only lowered when a gap follows, so it never drops and rises in one step.
	task automatic send_item(ctw_cmd_t op, logic [CHAR_W-1:0] ch,
			logic [CUR_COL_W-1:0] c, logic [CUR_ROW_W-1:0] r);
		int gap;
		gap = send_idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= op;
		char_code <= ch;
		col       <= c;
		row       <= r;
		do @(posedge clk); while (in_stall);
		expected_reports.push_back(console_update(op, ch, c, r));
	endtask

	// Sender pause: nothing offered until every outstanding report is back.
	task automatic drain_reports();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_reports.size() != 0);
	endtask

	// Writes both color registers back to back; only called with the console idle.
	task automatic set_colors(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FG;
		cfg_data  <= fg;
		@(posedge clk);
		fg_nib     = fg;
		cfg_index <= REG_BG;
		cfg_data  <= bg;
		@(posedge clk);
		bg_nib  = bg;
		cfg_we <= 1'b0;
	endtask

	// Every command at least once, field extremes, off-grid put-at and read, reset colors.
	task automatic test_basic_commands();
		send_item(CMD_CLEAR, 8'h00, 7'd0, 5'd0);
		send_item(CMD_PUTC, 8'h41, rand_col(), rand_row());
		send_item(CMD_PUTC, 8'h00, rand_col(), rand_row());
		send_item(CMD_PUTC, 8'hFF, 7'd127, 5'd31);
		send_item(CMD_PUTC, CHAR_CR, rand_col(), rand_row());
		send_item(CMD_PUTC, CHAR_TAB, rand_col(), rand_row());
		send_item(CMD_PUTC, CHAR_LF, rand_col(), rand_row());
		send_item(CMD_PUTAT, 8'h5A, CUR_COL_W'(GRID_COLS - 1), CUR_ROW_W'(GRID_ROWS - 1));
		send_item(CMD_PUTAT, 8'hFF, 7'd0, 5'd0);
		send_item(CMD_READ, 8'hFF, CUR_COL_W'(GRID_COLS - 1), CUR_ROW_W'(GRID_ROWS - 1));
		send_item(CMD_READ, 8'h00, 7'd0, 5'd0);
		send_item(CMD_READ, 8'h00, 7'd1, 5'd0);
		send_item(CMD_READ, 8'h00, 7'd2, 5'd0);
		send_item(CMD_READ, 8'h00, 7'd4, 5'd1);
		// off the grid: put-at is dropped, read gives zero, cursor stays
		send_item(CMD_PUTAT, 8'h11, CUR_COL_W'(GRID_COLS), 5'd0);
		send_item(CMD_PUTAT, 8'h22, 7'd127, 5'd31);
		send_item(CMD_READ, 8'h00, CUR_COL_W'(GRID_COLS), 5'd0);
		send_item(CMD_READ, 8'h00, 7'd127, 5'd31);
		send_item(CMD_READ, 8'h00, 7'd0, CUR_ROW_W'(GRID_ROWS));
		send_item(CMD_READ, 8'h00, CUR_COL_W'(GRID_COLS - 1), CUR_ROW_W'(GRID_ROWS - 1));
		drain_reports();
	endtask

	// Tab run from column 0 until one passes the right edge and wraps to the next row.
	task automatic test_tab_wrap();
		send_item(CMD_PUTC, CHAR_CR, rand_col(), rand_row());
		repeat (GRID_COLS / TAB_STEP) send_item(CMD_PUTC, CHAR_TAB, rand_col(), rand_row());
		drain_reports();
	endtask

	// Scroll by line feed, by printed wrap and by tab wrap on the last row.
	task automatic test_scroll();
		set_colors(4'h0, 4'hF);
		while (shadow_row != GRID_ROWS - 1)
			send_item(CMD_PUTC, CHAR_LF, rand_col(), rand_row());
		send_item(CMD_PUTC, CHAR_LF, rand_col(), rand_row());
		send_item(CMD_PUTC, CHAR_CR, rand_col(), rand_row());
		repeat (GRID_COLS / TAB_STEP - 1)
			send_item(CMD_PUTC, CHAR_TAB, rand_col(), rand_row());
		send_item(CMD_PUTC, 8'h61, rand_col(), rand_row());
		send_item(CMD_PUTC, 8'h62, rand_col(), rand_row());
		send_item(CMD_PUTC, 8'h63, rand_col(), rand_row());
		send_item(CMD_PUTC, 8'h64, rand_col(), rand_row());   // last column: wrap scrolls
		send_item(CMD_READ, 8'h00, CUR_COL_W'(GRID_COLS - 1), CUR_ROW_W'(GRID_ROWS - 2));
		send_item(CMD_READ, 8'h00, CUR_COL_W'(GRID_COLS - 4), CUR_ROW_W'(GRID_ROWS - 2));
		send_item(CMD_READ, 8'h00, 7'd0, CUR_ROW_W'(GRID_ROWS - 1));
		repeat (GRID_COLS / TAB_STEP)
			send_item(CMD_PUTC, CHAR_TAB, rand_col(), rand_row());
		send_item(CMD_READ, 8'h00, CUR_COL_W'(GRID_COLS - 1), CUR_ROW_W'(GRID_ROWS - 3));
		drain_reports();
	endtask

	// Receiver holds off long enough that the console backs up and stalls its input.
	task automatic test_backpressure();
		send_idle_on = 1'b0;
		hold_left    = HOLD_CYCLES;
		repeat (16)
			send_item(CMD_PUTC, CHAR_W'($urandom_range(32, 126)), rand_col(), rand_row());
		send_item(CMD_PUTAT, CHAR_W'($urandom_range(0, 255)), rand_col(), rand_row());
		send_item(CMD_READ, 8'h00, rand_col(), rand_row());
		drain_reports();
		send_idle_on = 1'b1;
	endtask

	// Mostly text lines and tab runs so the cursor reaches the bottom and keeps
	// scrolling, mixed with put-at/read-back pairs, clears and raw noise items.
	task automatic test_random_traffic();
		int sent;
		int pick;
		int len;
		logic [CUR_COL_W-1:0] c;
		logic [CUR_ROW_W-1:0] r;
		for (int chunk = 0; chunk < 6; chunk++) begin
			case (chunk)
			0: begin
				set_colors(4'hF, 4'hF);
			end
			1: begin
				set_colors(4'h0, 4'h0);
			end
			default: begin
				set_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
			end
			endcase
			sent = 0;
			while (sent < 75) begin
				// change idling now and then so there are stretches without gaps
				if ($urandom_range(0, 15) == 0) begin
					send_idle_on = $urandom_range(0, 2) != 0;
					recv_idle_on = $urandom_range(0, 2) != 0;
				end
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
						: $urandom_range(0, 12);
					repeat (len)
						send_item(CMD_PUTC, CHAR_W'($urandom_range(0, 255)), rand_col(),
							rand_row());
					if ($urandom_range(0, 3) != 0)
						send_item(CMD_PUTC, CHAR_CR, rand_col(), rand_row());
					send_item(CMD_PUTC, CHAR_LF, rand_col(), rand_row());
					sent += len + 2;
				end else if (pick < 55) begin
					len = $urandom_range(1, 24);
					repeat (len) send_item(CMD_PUTC, CHAR_TAB, rand_col(), rand_row());
					sent += len;
				end else if (pick < 70) begin
					c = rand_col();
					r = rand_row();
					send_item(CMD_PUTAT, CHAR_W'($urandom_range(0, 255)), c, r);
					send_item(CMD_READ, CHAR_W'($urandom_range(0, 255)), c, r);
					sent += 2;
				end else if (pick < 85) begin
					send_item(CMD_READ, CHAR_W'($urandom_range(0, 255)), rand_col(),
						rand_row());
					sent++;
				end else if (pick < 92) begin
					send_item(ctw_cmd_t'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
						CUR_COL_W'($urandom_range(0, 127)), CUR_ROW_W'($urandom_range(0, 31)));
					sent++;
				end else if (pick < 94) begin
					send_item(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)), rand_col(),
						rand_row());
					sent++;
				end else begin
					len = $urandom_range(1, 6);
					repeat (len) send_item(CMD_PUTC, CHAR_LF, rand_col(), rand_row());
					sent += len;
				end
			end
			drain_reports();
		end
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
	endtask

	// Result sink: checks each accepted report against the oldest expectation and
	// draws its own stall pattern; a pending long hold-off overrides the pattern.
	initial begin : result_sink
		int              stall_left;
		console_report_t exp_r;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$error("report item with nothing expected");
					fail_count++;
				end else begin
					exp_r = expected_reports.pop_front();
					if (cursor_col !== exp_r.ccol) begin
						$error("cursor_col: expected %0d, got %0d", exp_r.ccol, cursor_col);
						fail_count++;
					end
					if (cursor_row !== exp_r.crow) begin
						$error("cursor_row: expected %0d, got %0d", exp_r.crow, cursor_row);
						fail_count++;
					end
					if (cursor_linear !== exp_r.clin) begin
						$error("cursor_linear: expected %0d, got %0d", exp_r.clin,
							cursor_linear);
						fail_count++;
					end
					if (cell_data !== exp_r.data) begin
						$error("cell_data: expected %h, got %h", exp_r.data, cell_data);
						fail_count++;
					end
					if (scrolled !== exp_r.scr) begin
						$error("scrolled: expected %0d, got %0d", exp_r.scr, scrolled);
						fail_count++;
					end
				end
				stall_left = recv_idle_on ? $urandom_range(0, 7) : 0;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= (stall_left != 0);
			end
		end
	end

	// Watchdog: too long without any handshake or register write means a hang.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		cmd       <= CMD_PUTC;
		char_code <= '0;
		col       <= '0;
		row       <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_FG;
		cfg_data  <= '0;
		for (int k = 0; k < GRID_CELLS; k++)
			shadow_cells[k] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// grid is undefined out of reset: the first command is a clear
		test_basic_commands();
		test_tab_wrap();
		test_scroll();
		test_backpressure();
		test_random_traffic();

		// anything arriving late shows up as an unexpected report
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_reports.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/ctw_pkg.sv
rtl/core/ctw_ram.sv
rtl/core/ctw_sweep.sv
rtl/core/text_console_writer.sv
verif/tb_text_console_writer.sv
